[rtl/core/radial_gradient_projection_defines.svh]
// Assertion macros for the radial gradient projection block.
// Both expect signals clk and arst_n in the scope where they are used.
`ifndef RADIAL_GRADIENT_PROJECTION_DEFINES_SVH
`define RADIAL_GRADIENT_PROJECTION_DEFINES_SVH

// same-cycle implication
`define RGP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rgp assertion failed");

// next-cycle implication
`define RGP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rgp assertion failed");

`endif

[rtl/core/rgp_pkg.sv]
// ----------------------------------------------------------------------------
// rgp_pkg
// Types, widths and codes shared by the radial gradient projection block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgp_pkg;

	localparam int COORD_BITS = 10;
	localparam int IDX_W      = 10;
	localparam int CRD_W      = 18;
	localparam int SCL_W      = 16;
	localparam int GRAD_W     = 16;
	localparam int RES_W      = 16;
	localparam int CFG_W      = 18;

	localparam logic [IDX_W-1:0] IDX_MASK = (COORD_BITS >= IDX_W) ? '1 :
		IDX_W'((64'd1 << COORD_BITS) - 64'd1);

	localparam int OFS_W  = 20;         // signed Q.8 offset
	localparam int PROD_W = OFS_W + SCL_W + 1;
	localparam int SS_W   = 24;         // signed scaled slice offset
	localparam int SQR_W  = 2 * OFS_W;
	localparam int N2_W   = 46;
	localparam int DOT_W  = 42;
	localparam int DMAG_W = DOT_W;

	localparam int ROOT_W    = 26;
	localparam int RAD_W     = 2 * ROOT_W;
	localparam int REM_W     = ROOT_W + 3;
	localparam int SQ_PER    = 2;
	localparam int SQ_STAGES = ROOT_W / SQ_PER;

	localparam int NUM_W      = DMAG_W + 3;
	localparam int Q_W        = 16;
	localparam int DREM_W     = ROOT_W + 1;
	localparam int DIV_PER    = 2;
	localparam int DIV_STAGES = Q_W / DIV_PER;

	localparam logic [SCL_W-1:0] SCALE_RESET = 16'd4096;

	typedef enum logic [1:0] {
		REG_CENTER_SLICE = 2'd0,
		REG_CENTER_ROW   = 2'd1,
		REG_CENTER_COL   = 2'd2,
		REG_SLICE_SCALE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [IDX_W-1:0]         slice_idx;
		logic [IDX_W-1:0]         row_idx;
		logic [IDX_W-1:0]         col_idx;
		logic signed [GRAD_W-1:0] grad_slice;
		logic signed [GRAD_W-1:0] grad_row;
		logic signed [GRAD_W-1:0] grad_col;
	} vox_t;

	typedef struct packed {
		logic signed [RES_W-1:0] radial_value;
		logic                    is_center;
	} res_t;

	typedef struct packed {
		logic [CRD_W-1:0] center_slice;
		logic [CRD_W-1:0] center_row;
		logic [CRD_W-1:0] center_col;
		logic [SCL_W-1:0] slice_scale;
	} cfg_t;

	// carried alongside the norm computation
	typedef struct packed {
		logic [DMAG_W-1:0] dmag;
		logic              neg;
		logic              center;
	} side_t;

endpackage

[rtl/core/rgp_front.sv]
// ----------------------------------------------------------------------------
// rgp_front
// Offsets, anisotropy scaling, squared norm and dot product over five stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgp_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  rgp_pkg::vox_t                    in_data,
	input  rgp_pkg::cfg_t                    cfg,
	output logic                             out_valid,
	output logic [rgp_pkg::N2_W-1:0]         n2,
	output logic signed [rgp_pkg::DOT_W-1:0] dot
);

	localparam int OW = rgp_pkg::OFS_W;
	localparam int GW = rgp_pkg::GRAD_W;

	logic [rgp_pkg::IDX_W-1:0] si_m, ri_m, ci_m;
	logic signed [OW-1:0] os_c, or_c, oc_c;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic signed [OW-1:0] os_s1, or_s1, oc_s1;
	logic signed [GW-1:0] gs_s1, gr_s1, gc_s1;

	logic signed [rgp_pkg::PROD_W-1:0] prod_s2;
	logic signed [rgp_pkg::SQR_W-1:0]  rr_s2, cc_s2;
	logic signed [OW+GW-1:0]           rg_s2, cg_s2;
	logic signed [GW-1:0]              gs_s2;

	logic [rgp_pkg::PROD_W-1:0]      pmag;
	logic [rgp_pkg::PROD_W-1:0]      smag;
	logic signed [rgp_pkg::SS_W-1:0] ss_c;

	logic signed [rgp_pkg::SS_W-1:0]  ss_s3;
	logic signed [rgp_pkg::SQR_W-1:0] rr_s3, cc_s3;
	logic signed [OW+GW-1:0]          rg_s3, cg_s3;
	logic signed [GW-1:0]             gs_s3;

	logic signed [2*rgp_pkg::SS_W-1:0]  sq_s4;
	logic signed [rgp_pkg::SS_W+GW-1:0] sg_s4;
	logic signed [rgp_pkg::SQR_W-1:0]   rr_s4, cc_s4;
	logic signed [OW+GW-1:0]            rg_s4, cg_s4;

	logic [rgp_pkg::N2_W-1:0]         n2_s5;
	logic signed [rgp_pkg::DOT_W-1:0] dot_s5;

	always_comb begin
		si_m = in_data.slice_idx & rgp_pkg::IDX_MASK;
		ri_m = in_data.row_idx & rgp_pkg::IDX_MASK;
		ci_m = in_data.col_idx & rgp_pkg::IDX_MASK;
		os_c = $signed({2'b00, cfg.center_slice}) - $signed({2'b00, si_m, 8'h00});
		or_c = $signed({2'b00, cfg.center_row}) - $signed({2'b00, ri_m, 8'h00});
		oc_c = $signed({2'b00, cfg.center_col}) - $signed({2'b00, ci_m, 8'h00});
	end

	// round Q.20 to Q.8, ties away from zero
	always_comb begin
		pmag = prod_s2[rgp_pkg::PROD_W-1] ? rgp_pkg::PROD_W'(-prod_s2) :
			rgp_pkg::PROD_W'(prod_s2);
		smag = (pmag + rgp_pkg::PROD_W'(2048)) >> 12;
		ss_c = $signed({1'b0, smag[rgp_pkg::SS_W-2:0]});
		if (prod_s2[rgp_pkg::PROD_W-1]) begin
			ss_c = -ss_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			os_s1 <= os_c;
			or_s1 <= or_c;
			oc_s1 <= oc_c;
			gs_s1 <= in_data.grad_slice;
			gr_s1 <= in_data.grad_row;
			gc_s1 <= in_data.grad_col;

			prod_s2 <= os_s1 * $signed({1'b0, cfg.slice_scale});
			rr_s2   <= or_s1 * or_s1;
			cc_s2   <= oc_s1 * oc_s1;
			rg_s2   <= or_s1 * gr_s1;
			cg_s2   <= oc_s1 * gc_s1;
			gs_s2   <= gs_s1;

			ss_s3 <= ss_c;
			rr_s3 <= rr_s2;
			cc_s3 <= cc_s2;
			rg_s3 <= rg_s2;
			cg_s3 <= cg_s2;
			gs_s3 <= gs_s2;

			sq_s4 <= ss_s3 * ss_s3;
			sg_s4 <= ss_s3 * gs_s3;
			rr_s4 <= rr_s3;
			cc_s4 <= cc_s3;
			rg_s4 <= rg_s3;
			cg_s4 <= cg_s3;

			n2_s5  <= rgp_pkg::N2_W'(sq_s4) + rgp_pkg::N2_W'(rr_s4) + rgp_pkg::N2_W'(cc_s4);
			dot_s5 <= rgp_pkg::DOT_W'(sg_s4) + rgp_pkg::DOT_W'(rg_s4) +
				rgp_pkg::DOT_W'(cg_s4);
		end
	end

	assign out_valid = valid_s5;
	assign n2        = n2_s5;
	assign dot       = dot_s5;

endmodule

[rtl/core/rgp_sqrt.sv]
// ----------------------------------------------------------------------------
// rgp_sqrt
// Pipelined digit-by-digit integer square root, two root bits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgp_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [rgp_pkg::RAD_W-1:0]     rad,
	input  rgp_pkg::side_t                in_side,
	output logic                          out_valid,
	output logic [rgp_pkg::ROOT_W-1:0]    root,
	output rgp_pkg::side_t                out_side
);

	localparam int NS = rgp_pkg::SQ_STAGES;

	typedef struct packed {
		logic [rgp_pkg::REM_W-1:0]  rem;
		logic [rgp_pkg::ROOT_W-1:0] root;
		logic [rgp_pkg::RAD_W-1:0]  rad;
	} sq_t;

	function automatic sq_t sq_step(input sq_t a);
		logic [rgp_pkg::REM_W-1:0] r;
		logic [rgp_pkg::REM_W-1:0] t;
		sq_t b;
		r = {a.rem[rgp_pkg::REM_W-3:0], a.rad[rgp_pkg::RAD_W-1 -: 2]};
		t = {1'b0, a.root, 2'b01};
		b.rad = {a.rad[rgp_pkg::RAD_W-3:0], 2'b00};
		if (r >= t) begin
			b.rem  = r - t;
			b.root = {a.root[rgp_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			b.rem  = r;
			b.root = {a.root[rgp_pkg::ROOT_W-2:0], 1'b0};
		end
		return b;
	endfunction

	logic           vld_s  [NS];
	sq_t            st_s   [NS];
	rgp_pkg::side_t side_s [NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		sq_t            cur;
		sq_t            nxt;
		logic           vin;
		rgp_pkg::side_t sin;

		if (k == 0) begin : g_first
			assign cur = '{rem: '0, root: '0, rad: rad};
			assign vin = in_valid;
			assign sin = in_side;
		end else begin : g_next
			assign cur = st_s[k-1];
			assign vin = vld_s[k-1];
			assign sin = side_s[k-1];
		end

		always_comb begin
			nxt = cur;
			for (int j = 0; j < rgp_pkg::SQ_PER; j++) begin
				nxt = sq_step(nxt);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k]   <= nxt;
				side_s[k] <= sin;
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign root      = st_s[NS-1].root;
	assign out_side  = side_s[NS-1];

endmodule

[rtl/core/rgp_div.sv]
// ----------------------------------------------------------------------------
// rgp_div
// Pipelined restoring divider: round(4*|dot| / norm) with overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [rgp_pkg::ROOT_W-1:0]    norm,
	input  rgp_pkg::side_t                in_side,
	output logic                          out_valid,
	output logic [rgp_pkg::Q_W-1:0]       quot,
	output logic                          ovf,
	output rgp_pkg::side_t                out_side
);

	localparam int NS = rgp_pkg::DIV_STAGES;
	localparam int QW = rgp_pkg::Q_W;
	localparam int DW = rgp_pkg::ROOT_W;

	typedef struct packed {
		logic [rgp_pkg::DREM_W-1:0] rem;
		logic [QW-1:0]              q;
		logic [QW-1:0]              lo;
		logic [DW-1:0]              d;
		logic                       ovf;
		logic                       neg;
		logic                       center;
	} dv_t;

	function automatic dv_t dv_step(input dv_t a);
		logic [rgp_pkg::DREM_W-1:0] r;
		dv_t b;
		b = a;
		r = {a.rem[rgp_pkg::DREM_W-2:0], a.lo[QW-1]};
		b.lo = {a.lo[QW-2:0], 1'b0};
		if (r >= {1'b0, a.d}) begin
			b.rem = r - {1'b0, a.d};
			b.q   = {a.q[QW-2:0], 1'b1};
		end else begin
			b.rem = r;
			b.q   = {a.q[QW-2:0], 1'b0};
		end
		return b;
	endfunction

	logic                      valid_s1, valid_s2;
	logic [rgp_pkg::NUM_W-1:0] num_s1;
	logic [DW-1:0]             d_s1;
	rgp_pkg::side_t            side_s1;
	dv_t                       init_s2;

	logic ovf_c;

	logic vld_s [NS];
	dv_t  st_s  [NS];

	// quotient would need more than Q_W bits
	assign ovf_c = num_s1 >= rgp_pkg::NUM_W'({d_s1, {QW{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= rgp_pkg::NUM_W'({in_side.dmag, 2'b00}) + rgp_pkg::NUM_W'(norm >> 1);
			d_s1    <= norm;
			side_s1 <= in_side;

			init_s2.rem    <= rgp_pkg::DREM_W'(num_s1 >> QW);
			init_s2.q      <= '0;
			init_s2.lo     <= num_s1[QW-1:0];
			init_s2.d      <= d_s1;
			init_s2.ovf    <= ovf_c;
			init_s2.neg    <= side_s1.neg;
			init_s2.center <= side_s1.center;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_stage
		dv_t  cur;
		dv_t  nxt;
		logic vin;

		if (k == 0) begin : g_first
			assign cur = init_s2;
			assign vin = valid_s2;
		end else begin : g_next
			assign cur = st_s[k-1];
			assign vin = vld_s[k-1];
		end

		always_comb begin
			nxt = cur;
			for (int j = 0; j < rgp_pkg::DIV_PER; j++) begin
				nxt = dv_step(nxt);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k] <= nxt;
			end
		end
	end

	assign out_valid       = vld_s[NS-1];
	assign quot            = st_s[NS-1].q;
	assign ovf             = st_s[NS-1].ovf;
	assign out_side.dmag   = '0;
	assign out_side.neg    = st_s[NS-1].neg;
	assign out_side.center = st_s[NS-1].center;

endmodule

[rtl/core/radial_gradient_projection.sv]
// ----------------------------------------------------------------------------
// radial_gradient_projection
// Projects each voxel's gradient onto the direction toward a set center.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// vox     | in        | vox_valid/vox_stall  | vox (rgp_pkg::vox_t)
// res     | out       | res_valid/res_stall  | res (rgp_pkg::res_t)
// cfg     | in        | cfg_we               | cfg_index, cfg_wdata
//
// One voxel per cycle unless a held result is stalled; the pipe is the 5-stage
// front end, then the 13-stage square root, the 10-stage divider and the result register.
// Reset clears all stage valids and loads the register defaults.
// Any stall on a held result freezes every stage at once; nothing is lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radial_gradient_projection (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         vox_valid,
	output logic                         vox_stall,
	input  rgp_pkg::vox_t                vox,
	output logic                         res_valid,
	input  logic                         res_stall,
	output rgp_pkg::res_t                res,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [rgp_pkg::CFG_W-1:0]    cfg_wdata
);

	rgp_pkg::cfg_t cfg_q;
	logic          en;

	logic                             fr_valid;
	logic [rgp_pkg::N2_W-1:0]         fr_n2;
	logic signed [rgp_pkg::DOT_W-1:0] fr_dot;
	rgp_pkg::side_t                   fr_side;

	logic                       sq_valid;
	logic [rgp_pkg::ROOT_W-1:0] sq_root;
	rgp_pkg::side_t             sq_side;

	logic                    dv_valid;
	logic [rgp_pkg::Q_W-1:0] dv_q;
	logic                    dv_ovf;
	rgp_pkg::side_t          dv_side;

	logic          res_valid_q;
	rgp_pkg::res_t res_q;
	rgp_pkg::res_t res_c;

	// whole pipeline advances unless a finished result is held
	assign en        = !res_valid_q || !res_stall;
	assign vox_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_slice <= '0;
			cfg_q.center_row   <= '0;
			cfg_q.center_col   <= '0;
			cfg_q.slice_scale  <= rgp_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			case (rgp_pkg::reg_idx_t'(cfg_index))
				rgp_pkg::REG_CENTER_SLICE: cfg_q.center_slice <= cfg_wdata;
				rgp_pkg::REG_CENTER_ROW:   cfg_q.center_row   <= cfg_wdata;
				rgp_pkg::REG_CENTER_COL:   cfg_q.center_col   <= cfg_wdata;
				rgp_pkg::REG_SLICE_SCALE:  cfg_q.slice_scale  <= cfg_wdata[rgp_pkg::SCL_W-1:0];
				default: ;
			endcase
		end
	end

	rgp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vox_valid),
		.in_data   (vox),
		.cfg       (cfg_q),
		.out_valid (fr_valid),
		.n2        (fr_n2),
		.dot       (fr_dot)
	);

	always_comb begin
		fr_side.neg    = fr_dot[rgp_pkg::DOT_W-1];
		fr_side.dmag   = fr_side.neg ? rgp_pkg::DMAG_W'(-fr_dot) : rgp_pkg::DMAG_W'(fr_dot);
		fr_side.center = (fr_n2 == '0);
	end

	rgp_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.rad       (rgp_pkg::RAD_W'({fr_n2, 4'b0000})),
		.in_side   (fr_side),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	rgp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.norm      (sq_root),
		.in_side   (sq_side),
		.out_valid (dv_valid),
		.quot      (dv_q),
		.ovf       (dv_ovf),
		.out_side  (dv_side)
	);

	// sign and saturation
	always_comb begin
		res_c.is_center = dv_side.center;
		if (dv_side.center) begin
			res_c.radial_value = '0;
		end else if (dv_side.neg) begin
			if (dv_ovf || dv_q > 16'd32768) begin
				res_c.radial_value = 16'sh8000;
			end else begin
				res_c.radial_value = $signed(-dv_q);
			end
		end else begin
			if (dv_ovf || dv_q > 16'd32767) begin
				res_c.radial_value = 16'sh7FFF;
			end else begin
				res_c.radial_value = $signed(dv_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_c;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[rtl/core/rgp_checker.sv]
// ----------------------------------------------------------------------------
// rgp_checker
// Port-level checks on the radial gradient projection block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radial_gradient_projection_defines.svh"

module rgp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          vox_stall,
	input logic          res_valid,
	input logic          res_stall,
	input rgp_pkg::res_t res
);

	`RGP_ASSERT_NOW(a_center_zero, res_valid && res.is_center, res.radial_value == 16'sd0)
	`RGP_ASSERT_NOW(a_stall_back, res_valid && res_stall, vox_stall)
	`RGP_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid)
	`RGP_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(res))

endmodule

bind radial_gradient_projection rgp_checker u_rgp_checker (.*);

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for radial_gradient_projection. A predictor computes the
// expected radial value and center flag per voxel with 64-bit integer math;
// results are checked in order against that. Registers are rewritten between
// phases while the pipe is empty; random input gaps and output stalls apply in some phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import rgp_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int VOX_W        = $bits(vox_t);

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           vox_valid = 1'b0;
	logic           vox_stall;
	vox_t           vox = '0;
	logic           res_valid;
	logic           res_stall = 1'b0;
	res_t           res;
	logic           cfg_we = 1'b0;
	logic [1:0]     cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// predictor copy of the registers
	logic [CRD_W-1:0] m_cslice = '0, m_crow = '0, m_ccol = '0;
	logic [SCL_W-1:0] m_scale = SCALE_RESET;

	res_t expected_q[$];
	int   n_sent = 0, n_checked = 0, n_center = 0, n_sat = 0, n_errors = 0;
	int   n_cycles = 0, n_phases = 0;
	bit   idle_on = 1'b0;
	int   stall_left = 0;

	radial_gradient_projection dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic res_t project_radial(input vox_t v);
		longint os, orow, ocol, prod, pmag, ss, dot;
		longint unsigned n2, nrm, dmag, q;
		res_t r;
		os   = longint'(m_cslice) - longint'(v.slice_idx & IDX_MASK) * 256;
		orow = longint'(m_crow) - longint'(v.row_idx & IDX_MASK) * 256;
		ocol = longint'(m_ccol) - longint'(v.col_idx & IDX_MASK) * 256;
		prod = os * longint'(m_scale);
		pmag = prod < 0 ? -prod : prod;
		ss   = (pmag + 2048) >>> 12;
		if (prod < 0)
			ss = -ss;
		n2  = ss * ss + orow * orow + ocol * ocol;
		dot = ss * longint'(v.grad_slice) + orow * longint'(v.grad_row)
			+ ocol * longint'(v.grad_col);
		r = '0;
		if (n2 == 0) begin
			r.is_center = 1'b1;
		end else begin
			nrm  = int_sqrt(n2 << 4);
			dmag = dot < 0 ? -dot : dot;
			q    = ((dmag << 2) + (nrm >> 1)) / nrm;
			if (dot < 0)
				r.radial_value = q > 32768 ? -16'sd32768 : 16'(-longint'(q));
			else
				r.radial_value = q > 32767 ? 16'sd32767 : 16'(q);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		n_errors++;
		$display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_checked);
	endtask

	// result checker
	always @(posedge clk) begin
		res_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", res.radial_value, 0);
			end else begin
				e = expected_q.pop_front();
				if (res.radial_value !== e.radial_value)
					report_mismatch("radial_value", res.radial_value, e.radial_value);
				if (res.is_center !== e.is_center)
					report_mismatch("is_center", res.is_center, e.is_center);
				if (e.is_center)
					n_center++;
				if (e.radial_value == 16'sd32767 || e.radial_value == -16'sd32768)
					n_sat++;
			end
			n_checked++;
		end
	end

	// output stall bursts
	always @(posedge clk) begin
		int nxt;
		nxt = stall_left;
		if (nxt > 0)
			nxt--;
		else if (idle_on && $urandom_range(0, 7) == 0)
			nxt = $urandom_range(1, 10);
		stall_left <= nxt;
		res_stall <= (nxt > 0);
	end

	task automatic send_voxel(input vox_t v);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			vox_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		vox <= v;
		vox_valid <= 1'b1;
		do
			@(posedge clk);
		while (vox_stall);
		expected_q.push_back(project_radial(v));
		n_sent++;
	endtask

	task automatic wait_empty();
		vox_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_config(input logic [CFG_W-1:0] cs, input logic [CFG_W-1:0] cr,
		input logic [CFG_W-1:0] cc, input logic [CFG_W-1:0] sc);
		reg_idx_t order[4];
		logic [CFG_W-1:0] vals[4];
		wait_empty();
		repeat (DRAIN_CYCLES) @(posedge clk);
		order = '{REG_CENTER_SLICE, REG_CENTER_ROW, REG_CENTER_COL, REG_SLICE_SCALE};
		vals = '{cs, cr, cc, sc};
		foreach (order[i]) begin
			cfg_we <= 1'b1;
			cfg_index <= order[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		m_cslice = cs;
		m_crow = cr;
		m_ccol = cc;
		m_scale = sc[SCL_W-1:0];
		n_phases++;
	endtask

	function automatic vox_t make_voxel(input int s, input int r, input int c,
		input int gs, input int gr, input int gc);
		vox_t v;
		v.slice_idx = IDX_W'(s);
		v.row_idx = IDX_W'(r);
		v.col_idx = IDX_W'(c);
		v.grad_slice = GRAD_W'(gs);
		v.grad_row = GRAD_W'(gr);
		v.grad_col = GRAD_W'(gc);
		return v;
	endfunction

	function automatic vox_t random_voxel();
		vox_t v;
		v = VOX_W'({$urandom, $urandom, $urandom});
		// bias some voxels near the center so small offsets and exact hits occur
		if ($urandom_range(0, 3) == 0) begin
			v.slice_idx = IDX_W'((m_cslice >> 8) + $urandom_range(0, 2) - 1);
			v.row_idx = IDX_W'((m_crow >> 8) + $urandom_range(0, 2) - 1);
			v.col_idx = IDX_W'((m_ccol >> 8) + $urandom_range(0, 2) - 1);
		end
		if ($urandom_range(0, 7) == 0)
			v.grad_slice = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		return v;
	endfunction

	task automatic test_directed();
		// exact center, unit offsets along each axis, then far corners
		load_config(18'd5 << 8, 18'd5 << 8, 18'd5 << 8, 18'd4096);
		send_voxel(make_voxel(5, 5, 5, 1000, -1000, 77));
		send_voxel(make_voxel(4, 5, 5, 256, 0, 0));
		send_voxel(make_voxel(5, 6, 5, 0, 256, 0));
		send_voxel(make_voxel(5, 5, 6, 0, 0, -256));
		send_voxel(make_voxel(0, 0, 0, 32767, 32767, 32767));
		send_voxel(make_voxel(0, 0, 0, -32768, -32768, -32768));
		send_voxel(make_voxel(1023, 1023, 1023, -32768, -32768, -32768));
		// tiny scale: slice offset rounds away, center reached through slice
		load_config(18'd5 << 8, 18'd5 << 8, 18'd5 << 8, 18'd1);
		send_voxel(make_voxel(4, 5, 5, 32767, 0, 0));
		send_voxel(make_voxel(6, 5, 5, 100, 0, 0));
		send_voxel(make_voxel(0, 4, 5, 100, 200, 0));
		// zero scale and bits above the scale width
		load_config(18'h3ffff, 18'h3ffff, 18'h3ffff, 18'h30000);
		send_voxel(make_voxel(0, 0, 0, 32767, 32767, -32768));
		send_voxel(make_voxel(1023, 1023, 1023, 1, 1, 1));
		load_config(18'h3ffff, 18'd0, 18'd0, 18'h3ffff);
		send_voxel(make_voxel(0, 0, 0, 32767, 0, 0));
		send_voxel(make_voxel(1023, 1023, 1023, -32768, 32767, 32767));
		send_voxel(make_voxel(1023, 0, 0, 0, 0, 0));
		load_config(18'd0, 18'd0, 18'd0, 18'd4096);
		send_voxel(make_voxel(0, 0, 0, 5, 5, 5));
		send_voxel(make_voxel(1023, 1023, 1023, 32767, 32767, 32767));
		send_voxel(make_voxel(1, 0, 0, -1, 0, 0));
	endtask

	task automatic test_random(input int count, input bit hold_off);
		load_config(CFG_W'($urandom_range(0, 18'h3ffff)), CFG_W'($urandom_range(0, 18'h3ffff)),
			CFG_W'($urandom_range(0, 18'h3ffff)), CFG_W'($urandom_range(0, 18'h3ffff)));
		for (int i = 0; i < count; i++) begin
			if (hold_off && i == count / 2)
				wait_empty();
			send_voxel(random_voxel());
		end
	endtask

	task automatic test_grid_centers(input int count);
		// centers on whole voxels with unit scale so exact center hits come up
		load_config(18'($urandom_range(0, 1023)) << 8, 18'($urandom_range(0, 1023)) << 8,
			18'($urandom_range(0, 1023)) << 8, 18'd4096);
		for (int i = 0; i < count; i++)
			send_voxel(random_voxel());
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		idle_on = 1'b1;
		test_random(200, 1'b0);
		test_grid_centers(200);
		test_random(200, 1'b1);
		test_grid_centers(200);
		test_random(200, 1'b0);
		test_random(200, 1'b0);
		idle_on = 1'b0;
		test_random(180, 1'b0);
		test_grid_centers(150);
		wait_empty();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d voxels over %0d register settings, %0d checked", n_sent,
			n_phases, n_checked);
		$display("center hits %0d, saturated results %0d", n_center, n_sat);
		if (n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[radial_gradient_projection.f]
+incdir+rtl/core
rtl/core/rgp_pkg.sv
rtl/core/rgp_front.sv
rtl/core/rgp_sqrt.sv
rtl/core/rgp_div.sv
rtl/core/radial_gradient_projection.sv
rtl/core/rgp_checker.sv
verif/tb.sv
